/* sv/dc_pkg.sv */
// ----------------------------------------------------------------------------
// dc_pkg: shared types and constants of the write-through data cache
// Geometry, operation and status codes, line states and control structs.
// ----------------------------------------------------------------------------
package dc_pkg;

   localparam int WAYS       = 4;
   localparam int SETS       = 4;
   localparam int LINE_BYTES = 64;

   localparam int NLINES  = SETS * WAYS;
   localparam int OFF_W   = $clog2(LINE_BYTES);
   localparam int SET_B   = $clog2(SETS);
   localparam int SET_W   = (SETS > 1) ? SET_B : 1;
   localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int LIDX_W  = (NLINES > 1) ? $clog2(NLINES) : 1;
   localparam int TAG_W   = 64 - OFF_W - SET_B;
   localparam int STAMP_W = 32;
   localparam int LINE_W  = LINE_BYTES * 8;

   localparam logic [2:0] OP_READ  = 3'd0;
   localparam logic [2:0] OP_WRITE = 3'd1;
   localparam logic [2:0] OP_FILL  = 3'd2;
   localparam logic [2:0] OP_SNOOP = 3'd3;
   localparam logic [2:0] OP_INVAL = 3'd4;

   localparam logic [3:0] ST_HIT       = 4'd0;
   localparam logic [3:0] ST_MISS_SENT = 4'd1;
   localparam logic [3:0] ST_MISS_PEND = 4'd2;
   localparam logic [3:0] ST_NO_WAY    = 4'd3;
   localparam logic [3:0] ST_WR_BLOCK  = 4'd4;
   localparam logic [3:0] ST_LINE_INV  = 4'd5;
   localparam logic [3:0] ST_WR_SENT   = 4'd6;
   localparam logic [3:0] ST_ACCEPTED  = 4'd7;
   localparam logic [3:0] ST_BAD_RANGE = 4'd8;

   typedef enum logic [1:0] {
      LS_EMPTY, LS_LOADING, LS_FULL, LS_INVALID
   } line_state_type;

   typedef enum logic [1:0] {
      FSM_IDLE, FSM_LOOKUP, FSM_DATA, FSM_OUT
   } fsm_type;

   typedef struct packed {
      logic             hit;
      logic             alloc;
      logic [WAY_W-1:0] hit_way;
      logic [WAY_W-1:0] alloc_way;
   } lookup_type;

   // Byte lanes covered by an access of size bytes (1..8).
   function automatic logic [7:0] size_mask(input logic [3:0] size);
      logic [7:0] m;
      for (int k = 0; k < 8; k++) begin
         m[k] = (4'(k) < size);
      end
      return m;
   endfunction

endpackage

/* sv/dc_if.sv */
// ----------------------------------------------------------------------------
// dc_if: request and response channels of the data cache
// Valid/ready channels; a transfer happens when both are high at a clock edge.
// ----------------------------------------------------------------------------
interface dc_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  op;
   logic [63:0] address;
   logic [3:0]  size;
   logic [63:0] data;
   logic        last_beat;

   modport source (output valid, op, address, size, data, last_beat, input ready);
   modport sink   (input valid, op, address, size, data, last_beat, output ready);
endinterface

interface dc_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  status;
   logic [63:0] read_data;
   logic        req_valid;
   logic        req_write;
   logic [63:0] req_address;
   logic [6:0]  req_size;
   logic [63:0] req_data;

   modport source (output valid, status, read_data, req_valid, req_write, req_address,
                   req_size, req_data, input ready);
   modport sink   (input valid, status, read_data, req_valid, req_write, req_address,
                   req_size, req_data, output ready);
endinterface

/* sv/dc_ram.sv */
// ----------------------------------------------------------------------------
// dc_ram: generic single-write, single-read synchronous RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module dc_ram #(
   parameter int DEPTH = 4,
   parameter int WIDTH = 8
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

/* sv/dc_line_ram.sv */
// ----------------------------------------------------------------------------
// dc_line_ram: line data store with byte write enables
// One row per line; write one row with byte enables, read one row registered.
// ----------------------------------------------------------------------------
module dc_line_ram (
   input  logic                          clock,
   input  logic                          we,
   input  logic [dc_pkg::LIDX_W-1:0]     wrow,
   input  logic [dc_pkg::LINE_BYTES-1:0] be,
   input  logic [dc_pkg::LINE_W-1:0]     wdata,
   input  logic [dc_pkg::LIDX_W-1:0]     rrow,
   output logic [dc_pkg::LINE_W-1:0]     rdata
);
   logic [7:0] mem [dc_pkg::NLINES][dc_pkg::LINE_BYTES];

   always_ff @(posedge clock) begin
      for (int b = 0; b < dc_pkg::LINE_BYTES; b++) begin
         if (we && be[b]) begin
            mem[wrow][b] <= wdata[b*8 +: 8];
         end
         rdata[b*8 +: 8] <= mem[rrow][b];
      end
   end
endmodule

/* sv/dc_lookup.sv */
// ----------------------------------------------------------------------------
// dc_lookup: way selection for one set
// Finds the matching way, else an empty way, else the oldest full way.
// ----------------------------------------------------------------------------
module dc_lookup (
   input  logic [dc_pkg::TAG_W-1:0]                   tag,
   input  logic [dc_pkg::WAYS-1:0][dc_pkg::TAG_W-1:0]   way_tags,
   input  logic [dc_pkg::WAYS-1:0][dc_pkg::STAMP_W-1:0] way_stamps,
   input  dc_pkg::line_state_type [dc_pkg::WAYS-1:0]   way_states,
   output dc_pkg::lookup_type                          result
);
   always_comb begin
      logic                        empty_found;
      logic                        repl_found;
      logic [dc_pkg::WAY_W-1:0]    empty_way;
      logic [dc_pkg::WAY_W-1:0]    repl_way;
      logic [dc_pkg::STAMP_W-1:0]  repl_stamp;
      empty_found = 1'b0;
      repl_found  = 1'b0;
      empty_way   = '0;
      repl_way    = '0;
      repl_stamp  = '0;
      result      = '0;
      for (int w = 0; w < dc_pkg::WAYS; w++) begin
         if (way_states[w] == dc_pkg::LS_EMPTY) begin
            empty_found = 1'b1;
            empty_way   = dc_pkg::WAY_W'(w);
         end else if (way_tags[w] == tag) begin
            if (!result.hit) begin
               result.hit     = 1'b1;
               result.hit_way = dc_pkg::WAY_W'(w);
            end
         end else if (way_states[w] == dc_pkg::LS_FULL &&
                      (!repl_found || way_stamps[w] < repl_stamp)) begin
            repl_found = 1'b1;
            repl_way   = dc_pkg::WAY_W'(w);
            repl_stamp = way_stamps[w];
         end
      end
      result.alloc     = !result.hit && (empty_found || repl_found);
      result.alloc_way = empty_found ? empty_way : repl_way;
   end
endmodule

/* sv/set_assoc_write_through_dcache.sv */
// ----------------------------------------------------------------------------
// set_assoc_write_through_dcache: set-associative write-through data cache
// Tag/stamp RAM per way, a line data RAM, line states and byte valids in flops.
// ----------------------------------------------------------------------------
// Sequence: after the request transfer, a lookup and update state, then the response
// register; a read hit adds a line RAM read state between them.
// One item is in flight at a time: a new request is taken only when the FSM is
// idle, after the response has been taken.
// Reset: synchronous; clears line states, byte valids, access counter and FSM.
module set_assoc_write_through_dcache (
   input  logic           clock,
   input  logic           reset,
   dc_req_if.sink         req_ch,
   dc_rsp_if.source       rsp_ch
);
   typedef struct packed {
      logic [3:0]  status;
      logic [63:0] read_data;
      logic        req_valid;
      logic        req_write;
      logic [63:0] req_address;
      logic [6:0]  req_size;
      logic [63:0] req_data;
   } rsp_type;

   // FSM and captured item
   dc_pkg::fsm_type fsm_ff, fsm_in;
   logic [2:0]                 op_ff;
   logic [63:0]                addr_ff;
   logic [3:0]                 size_ff;
   logic [63:0]                data_ff;
   logic                       last_ff;
   logic [dc_pkg::STAMP_W-1:0] stamp_ff;
   logic [dc_pkg::STAMP_W-1:0] counter_ff;
   rsp_type                    out_ff, out_in;

   // Line state and byte valid flops
   dc_pkg::line_state_type    lstate_ff [dc_pkg::NLINES];
   logic [dc_pkg::LINE_BYTES-1:0] valid_ff [dc_pkg::NLINES];

   logic                         accept;
   logic [dc_pkg::SET_W-1:0]     req_set, set_ff_w;
   logic [dc_pkg::TAG_W-1:0]     tag_w;
   logic [dc_pkg::OFF_W-1:0]     off_w;

   assign accept  = req_ch.valid && req_ch.ready;
   assign req_set = (dc_pkg::SETS > 1) ? req_ch.address[dc_pkg::OFF_W +: dc_pkg::SET_W] : '0;
   assign set_ff_w = (dc_pkg::SETS > 1) ? addr_ff[dc_pkg::OFF_W +: dc_pkg::SET_W] : '0;
   assign tag_w   = addr_ff[63 -: dc_pkg::TAG_W];
   assign off_w   = addr_ff[dc_pkg::OFF_W-1:0];

   // Per-way tag and stamp RAMs, read at the set of the incoming item
   logic [dc_pkg::WAYS-1:0][dc_pkg::TAG_W-1:0]   way_tags;
   logic [dc_pkg::WAYS-1:0][dc_pkg::STAMP_W-1:0] way_stamps;
   dc_pkg::line_state_type [dc_pkg::WAYS-1:0]   way_states;
   logic [dc_pkg::WAYS-1:0]                     ts_we;
   logic [dc_pkg::TAG_W-1:0]                    ts_wtag;
   logic [dc_pkg::SET_W-1:0]                    ts_raddr;

   assign ts_raddr = (fsm_ff == dc_pkg::FSM_IDLE) ? req_set : set_ff_w;

   for (genvar w = 0; w < dc_pkg::WAYS; w++) begin : g_way
      dc_ram #(
         .DEPTH (dc_pkg::SETS),
         .WIDTH (dc_pkg::TAG_W + dc_pkg::STAMP_W)
      ) u_tag_ram (
         .clock (clock),
         .we    (ts_we[w]),
         .waddr (set_ff_w),
         .wdata ({ts_wtag, stamp_ff}),
         .raddr (ts_raddr),
         .rdata ({way_tags[w], way_stamps[w]})
      );
      assign way_states[w] = lstate_ff[dc_pkg::LIDX_W'(int'(set_ff_w) * dc_pkg::WAYS + w)];
   end

   dc_pkg::lookup_type lk;

   dc_lookup u_lookup (
      .tag        (tag_w),
      .way_tags   (way_tags),
      .way_stamps (way_stamps),
      .way_states (way_states),
      .result     (lk)
   );

   // Chosen line and its status
   logic [dc_pkg::WAY_W-1:0]      way_sel;
   logic [dc_pkg::LIDX_W-1:0]     lidx;
   dc_pkg::line_state_type        st;
   logic [dc_pkg::LINE_BYTES-1:0] vld;
   logic [dc_pkg::LINE_BYTES-1:0] acc_mask;
   logic [dc_pkg::LINE_BYTES-1:0] beat_mask;
   logic [dc_pkg::OFF_W-1:0]      beat_off;
   logic [7:0]                    smask;
   logic [63:0]                   dmask;
   logic                          bad;
   logic                          all_valid;

   assign way_sel  = lk.hit ? lk.hit_way : lk.alloc_way;
   assign lidx     = dc_pkg::LIDX_W'(int'(set_ff_w) * dc_pkg::WAYS + int'(way_sel));
   assign st       = lstate_ff[lidx];
   assign vld      = valid_ff[lidx];
   assign smask    = dc_pkg::size_mask(size_ff);
   assign acc_mask = dc_pkg::LINE_BYTES'(smask) << off_w;
   assign beat_off = off_w & ~dc_pkg::OFF_W'(7);
   assign beat_mask = dc_pkg::LINE_BYTES'(8'hff) << beat_off;
   assign all_valid = (vld & acc_mask) == acc_mask;

   always_comb begin
      for (int k = 0; k < 8; k++) begin
         dmask[k*8 +: 8] = {8{smask[k]}};
      end
   end

   assign bad = (op_ff > dc_pkg::OP_INVAL) ||
                ((size_ff == 4'd0 || size_ff > 4'd8 ||
                  (7'(off_w) + 7'(size_ff)) > 7'(dc_pkg::LINE_BYTES)) &&
                 (op_ff == dc_pkg::OP_READ || op_ff == dc_pkg::OP_WRITE ||
                  op_ff == dc_pkg::OP_SNOOP));

   // Line data RAM
   logic                          dw_we;
   logic [dc_pkg::LINE_BYTES-1:0] dw_be;
   logic [dc_pkg::LINE_W-1:0]     dw_data;
   logic [dc_pkg::LINE_W-1:0]     rd_row;
   logic [dc_pkg::LINE_W-1:0]     rd_shift;

   dc_line_ram u_line_ram (
      .clock (clock),
      .we    (dw_we),
      .wrow  (lidx),
      .be    (dw_be),
      .wdata (dw_data),
      .rrow  (lidx),
      .rdata (rd_row)
   );

   assign rd_shift = rd_row >> {off_w, 3'b000};

   // Line state / valid updates decided in the lookup cycle
   logic                          ls_we;
   dc_pkg::line_state_type        ls_new;
   logic                          vl_we;
   logic [dc_pkg::LINE_BYTES-1:0] vl_new;

   always_comb begin
      fsm_in  = fsm_ff;
      out_in  = out_ff;
      ts_we   = '0;
      ts_wtag = lk.hit ? way_tags[way_sel] : tag_w;
      dw_we   = 1'b0;
      dw_be   = acc_mask;
      dw_data = dc_pkg::LINE_W'(data_ff) << {off_w, 3'b000};
      ls_we   = 1'b0;
      ls_new  = st;
      vl_we   = 1'b0;
      vl_new  = vld;
      req_ch.ready = (fsm_ff == dc_pkg::FSM_IDLE);

      unique case (fsm_ff)
         dc_pkg::FSM_IDLE: begin
            if (accept) begin
               fsm_in = dc_pkg::FSM_LOOKUP;
            end
         end
         dc_pkg::FSM_LOOKUP: begin
            out_in = '0;
            out_in.status = dc_pkg::ST_ACCEPTED;
            fsm_in = dc_pkg::FSM_OUT;
            if (bad) begin
               out_in.status = dc_pkg::ST_BAD_RANGE;
            end else begin
               unique case (op_ff)
                  dc_pkg::OP_READ: begin
                     if (!lk.hit && !lk.alloc) begin
                        out_in.status = dc_pkg::ST_NO_WAY;
                     end else begin
                        // refresh stamp; claim the tag on allocation
                        ts_we[way_sel] = 1'b1;
                        if (lk.hit && all_valid) begin
                           fsm_in = dc_pkg::FSM_DATA;
                           out_in.status = dc_pkg::ST_HIT;
                        end else if (lk.hit && st == dc_pkg::LS_LOADING) begin
                           out_in.status = dc_pkg::ST_MISS_PEND;
                        end else if (lk.hit && st == dc_pkg::LS_INVALID) begin
                           out_in.status = dc_pkg::ST_LINE_INV;
                        end else begin
                           if (!lk.hit) begin
                              vl_we  = 1'b1;
                              vl_new = '0;
                           end
                           ls_we  = 1'b1;
                           ls_new = dc_pkg::LS_LOADING;
                           out_in.status      = dc_pkg::ST_MISS_SENT;
                           out_in.req_valid   = 1'b1;
                           out_in.req_address = {addr_ff[63:dc_pkg::OFF_W],
                                                 dc_pkg::OFF_W'(0)};
                           out_in.req_size    = 7'(dc_pkg::LINE_BYTES);
                        end
                     end
                  end
                  dc_pkg::OP_WRITE: begin
                     if (lk.hit && st == dc_pkg::LS_LOADING) begin
                        out_in.status = dc_pkg::ST_WR_BLOCK;
                     end else begin
                        dw_we = lk.hit && st == dc_pkg::LS_FULL;
                        out_in.status      = dc_pkg::ST_WR_SENT;
                        out_in.req_valid   = 1'b1;
                        out_in.req_write   = 1'b1;
                        out_in.req_address = addr_ff;
                        out_in.req_size    = 7'(size_ff);
                        out_in.req_data    = data_ff & dmask;
                     end
                  end
                  dc_pkg::OP_FILL: begin
                     if (lk.hit && st != dc_pkg::LS_FULL) begin
                        // fill only bytes not yet valid
                        dw_we   = 1'b1;
                        dw_be   = beat_mask & ~vld;
                        dw_data = dc_pkg::LINE_W'(data_ff) << {beat_off, 3'b000};
                        vl_we   = 1'b1;
                        vl_new  = vld | beat_mask;
                        if (last_ff) begin
                           ls_we  = 1'b1;
                           ls_new = (st == dc_pkg::LS_INVALID) ? dc_pkg::LS_EMPTY
                                                               : dc_pkg::LS_FULL;
                        end
                     end
                  end
                  dc_pkg::OP_SNOOP: begin
                     if (lk.hit) begin
                        dw_we  = 1'b1;
                        vl_we  = 1'b1;
                        vl_new = vld | acc_mask;
                     end
                  end
                  dc_pkg::OP_INVAL: begin
                     if (lk.hit && st == dc_pkg::LS_FULL) begin
                        ls_we  = 1'b1;
                        ls_new = dc_pkg::LS_EMPTY;
                     end else if (lk.hit && st == dc_pkg::LS_LOADING) begin
                        ls_we  = 1'b1;
                        ls_new = dc_pkg::LS_INVALID;
                     end
                  end
                  default: begin
                     out_in.status = dc_pkg::ST_BAD_RANGE;
                  end
               endcase
            end
         end
         dc_pkg::FSM_DATA: begin
            out_in.read_data = rd_shift[63:0] & dmask;
            fsm_in = dc_pkg::FSM_OUT;
         end
         dc_pkg::FSM_OUT: begin
            if (rsp_ch.ready) begin
               fsm_in = dc_pkg::FSM_IDLE;
            end
         end
         default: begin
            fsm_in = dc_pkg::FSM_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff     <= dc_pkg::FSM_IDLE;
         counter_ff <= '0;
         for (int i = 0; i < dc_pkg::NLINES; i++) begin
            lstate_ff[i] <= dc_pkg::LS_EMPTY;
            valid_ff[i]  <= '0;
         end
      end else begin
         fsm_ff <= fsm_in;
         if (accept) begin
            counter_ff <= counter_ff + 1'b1;
         end
         if (fsm_ff == dc_pkg::FSM_LOOKUP && ls_we) begin
            lstate_ff[lidx] <= ls_new;
         end
         if (fsm_ff == dc_pkg::FSM_LOOKUP && vl_we) begin
            valid_ff[lidx] <= vl_new;
         end
      end
   end

   // Payload: capture the item on transfer, hold the response
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_ch.op;
         addr_ff  <= req_ch.address;
         size_ff  <= req_ch.size;
         data_ff  <= req_ch.data;
         last_ff  <= req_ch.last_beat;
         stamp_ff <= counter_ff;
      end
      out_ff  <= out_in;
   end

   assign rsp_ch.valid       = (fsm_ff == dc_pkg::FSM_OUT);
   assign rsp_ch.status      = out_ff.status;
   assign rsp_ch.read_data   = out_ff.read_data;
   assign rsp_ch.req_valid   = out_ff.req_valid;
   assign rsp_ch.req_write   = out_ff.req_write;
   assign rsp_ch.req_address = out_ff.req_address;
   assign rsp_ch.req_size    = out_ff.req_size;
   assign rsp_ch.req_data    = out_ff.req_data;
endmodule
